// ===== rtl/core/jkv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_pkg
// Shared types and constants of the JSON key/value span scanner.
// ----------------------------------------------------------------------------
package jkv_pkg;

	localparam int ID_W  = 10;
	localparam int OFS_W = 32;

	// parse phases
	typedef enum logic [3:0] {
		PH_OPEN     = 4'd0,
		PH_KEY_WAIT = 4'd1,
		PH_IN_KEY   = 4'd2,
		PH_COLON    = 4'd3,
		PH_VALUE    = 4'd4,
		PH_STR      = 4'd5,
		PH_LIST     = 4'd6,
		PH_SCALAR   = 4'd7,
		PH_AFTER    = 4'd8,
		PH_DONE     = 4'd9,
		PH_ERR      = 4'd10
	} phase_t;

	// record kinds
	localparam logic [1:0] KIND_SCALAR = 2'd0;
	localparam logic [1:0] KIND_STRING = 2'd1;
	localparam logic [1:0] KIND_LIST   = 2'd2;
	localparam logic [1:0] KIND_OBJECT = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_SYNTAX   = 2'd1;
	localparam logic [1:0] ERR_STACK    = 2'd2;
	localparam logic [1:0] ERR_RECORDS  = 2'd3;

	// structural characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	// one result record
	typedef struct packed {
		logic [1:0]       kind;
		logic [ID_W-1:0]  id;
		logic [ID_W-1:0]  parent;
		logic             has_parent;
		logic [OFS_W-1:0] ks;
		logic [OFS_W-1:0] ke;
		logic [OFS_W-1:0] vs;
		logic [OFS_W-1:0] ve;
		logic [1:0]       err;
		logic             last;
	} rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/jkv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_front
// Byte classifier and parse state; produces up to two records per byte.
// ----------------------------------------------------------------------------
module jkv_front #(
	parameter int STACK_DEPTH = 32,
	parameter int MAX_RECORDS = 1024,
	parameter int POS_BITS    = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         acc,
	input  wire logic [7:0]   byte_in,
	input  wire logic         end_of_doc,
	output jkv_pkg::rec_t     rec0,
	output jkv_pkg::rec_t     rec1,
	output logic [1:0]        rec_cnt
);
	import jkv_pkg::*;

	localparam int DW   = $clog2(STACK_DEPTH + 1);
	localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int NW   = $clog2(MAX_RECORDS + 1);

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [POS_BITS-1:0] ks;
		logic [POS_BITS-1:0] ke;
		logic [POS_BITS-1:0] vs;
	} ent_t;

	phase_t              ph_q, ph_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [7:0]          ld_q, ld_d;
	logic [1:0]          esc_q, esc_d;
	logic [POS_BITS-1:0] ks_q, ks_d, ke_q, ke_d, vs_q, vs_d;
	logic [NW-1:0]       nid_q, nid_d;
	logic [ID_W-1:0]     cid_q, cid_d;
	logic [DW-1:0]       dep_q, dep_d;
	ent_t                top_q, rd_q, new_ent;
	logic                push, pop;
	ent_t                mem [STACK_DEPTH];
	rec_t                recs [2];
	logic [1:0]          n;
	logic [POS_BITS-1:0] pos1;
	logic                ws;

	function automatic logic [OFS_W-1:0] ofs(input logic [POS_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[OFS_W-1:0];
	endfunction

	assign pos1 = pos_q + POS_BITS'(1);
	assign ws = (byte_in == 8'h20) || (byte_in == 8'h09) || (byte_in == 8'h0A) ||
		(byte_in == 8'h0B) || (byte_in == 8'h0C) || (byte_in == 8'h0D);

	// next state and records
	always_comb begin
		rec_t r;
		logic do_fail;
		logic [1:0] fcode;
		logic after;
		ph_d = ph_q; pos_d = pos1; ld_d = ld_q; esc_d = esc_q;
		ks_d = ks_q; ke_d = ke_q; vs_d = vs_q; nid_d = nid_q; cid_d = cid_q;
		dep_d = dep_q; push = 1'b0; pop = 1'b0; n = 2'd0;
		recs[0] = '0; recs[1] = '0; r = '0;
		do_fail = 1'b0; fcode = ERR_SYNTAX; after = 1'b0;
		new_ent = '{id: cid_q, ks: ks_q, ke: ke_q, vs: pos_q};
		case (ph_q)
			PH_OPEN: begin
				if (byte_in == CH_LBRACE) ph_d = PH_KEY_WAIT;
				else do_fail = 1'b1;
			end
			PH_KEY_WAIT: begin
				if (!ws) begin
					if (byte_in == CH_QUOTE) begin
						ks_d = pos1; esc_d = 2'd0; ph_d = PH_IN_KEY;
					end else do_fail = 1'b1;
				end
			end
			PH_IN_KEY: begin
				if (esc_q[1]) esc_d = 2'd0;
				else if (byte_in == CH_BSLASH) esc_d = 2'd2;
				else if (byte_in == CH_QUOTE) begin
					ke_d = pos_q;
					if (nid_q >= NW'(MAX_RECORDS)) begin
						do_fail = 1'b1; fcode = ERR_RECORDS;
					end else begin
						cid_d = ID_W'(nid_q); nid_d = nid_q + NW'(1); ph_d = PH_COLON;
					end
				end
			end
			PH_COLON: begin
				if (!ws) begin
					if (byte_in == CH_COLON) ph_d = PH_VALUE;
					else do_fail = 1'b1;
				end
			end
			PH_VALUE: begin
				if (!ws) begin
					vs_d = pos_q;
					if (byte_in == CH_LBRACE) begin
						if (dep_q >= DW'(STACK_DEPTH)) begin
							do_fail = 1'b1; fcode = ERR_STACK;
						end else begin
							push = 1'b1; dep_d = dep_q + DW'(1); ph_d = PH_KEY_WAIT;
						end
					end else if (byte_in == CH_QUOTE) begin
						esc_d = 2'd0; ph_d = PH_STR;
					end else if (byte_in == CH_LBRACK) begin
						ld_d = 8'd1; esc_d = 2'd0; ph_d = PH_LIST;
					end else if (byte_in == CH_RBRACE || byte_in == CH_COMMA) begin
						do_fail = 1'b1;
					end else ph_d = PH_SCALAR;
				end
			end
			PH_STR: begin
				if (esc_q[1]) esc_d = 2'd0;
				else if (byte_in == CH_BSLASH) esc_d = 2'd2;
				else if (byte_in == CH_QUOTE) begin
					r = '0; r.kind = KIND_STRING; r.id = cid_q;
					r.has_parent = (dep_q != '0); r.parent = r.has_parent ? top_q.id : '0;
					r.ks = ofs(ks_q); r.ke = ofs(ke_q); r.vs = ofs(vs_q); r.ve = ofs(pos1);
					recs[n[0]] = r; n = n + 2'd1;
					ph_d = PH_AFTER;
				end
			end
			PH_LIST: begin
				if (esc_q[0]) begin
					if (esc_q[1]) esc_d = 2'd1;
					else if (byte_in == CH_BSLASH) esc_d = 2'd3;
					else if (byte_in == CH_QUOTE) esc_d = 2'd0;
				end else if (byte_in == CH_QUOTE) esc_d = 2'd1;
				else if (byte_in == CH_LBRACK) begin
					if (ld_q == 8'd255) do_fail = 1'b1;
					else ld_d = ld_q + 8'd1;
				end else if (byte_in == CH_RBRACK) begin
					ld_d = ld_q - 8'd1;
					if (ld_d == 8'd0) begin
						r = '0; r.kind = KIND_LIST; r.id = cid_q;
						r.has_parent = (dep_q != '0); r.parent = r.has_parent ? top_q.id : '0;
						r.ks = ofs(ks_q); r.ke = ofs(ke_q); r.vs = ofs(vs_q); r.ve = ofs(pos1);
						recs[n[0]] = r; n = n + 2'd1;
						ph_d = PH_AFTER;
					end
				end
			end
			PH_SCALAR: begin
				if (byte_in == CH_RBRACE || byte_in == CH_COMMA) begin
					r = '0; r.kind = KIND_SCALAR; r.id = cid_q;
					r.has_parent = (dep_q != '0); r.parent = r.has_parent ? top_q.id : '0;
					r.ks = ofs(ks_q); r.ke = ofs(ke_q); r.vs = ofs(vs_q); r.ve = ofs(pos_q);
					recs[n[0]] = r; n = n + 2'd1;
					after = 1'b1;
				end
			end
			PH_AFTER: after = 1'b1;
			PH_DONE: begin
				if (!ws) do_fail = 1'b1;
			end
			default: ;
		endcase

		// handling after a finished value
		if (after) begin
			if (ws) ph_d = PH_AFTER;
			else if (byte_in == CH_RBRACE) begin
				if (dep_q != '0) begin
					pop = 1'b1; dep_d = dep_q - DW'(1);
					r = '0; r.kind = KIND_OBJECT; r.id = top_q.id;
					r.has_parent = (dep_d != '0); r.parent = r.has_parent ? rd_q.id : '0;
					r.ks = ofs(top_q.ks); r.ke = ofs(top_q.ke); r.vs = ofs(top_q.vs);
					r.ve = ofs(pos1);
					recs[n[0]] = r; n = n + 2'd1;
					ph_d = PH_AFTER;
				end else ph_d = PH_DONE;
			end else if (byte_in == CH_COMMA) ph_d = PH_KEY_WAIT;
			else do_fail = 1'b1;
		end

		// error transaction
		if (do_fail) begin
			r = '0; r.err = fcode;
			recs[n[0]] = r; n = n + 2'd1;
			ph_d = PH_ERR;
		end

		// end of document
		if (end_of_doc) begin
			if (ph_d != PH_DONE && ph_d != PH_ERR) begin
				if (n != 2'd0) recs[n[0] ^ 1'b1].err = ERR_SYNTAX;
				else begin
					r = '0; r.err = ERR_SYNTAX;
					recs[0] = r; n = 2'd1;
				end
			end
			ph_d = PH_OPEN; pos_d = '0; ld_d = '0; esc_d = '0;
			ks_d = '0; ke_d = '0; vs_d = '0; nid_d = '0; cid_d = '0; dep_d = '0;
		end
		if (n != 2'd0) recs[n[0] ^ 1'b1].last = 1'b1;
	end

	assign rec0 = recs[0];
	assign rec1 = recs[1];
	assign rec_cnt = acc ? n : 2'd0;

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_OPEN; pos_q <= '0; ld_q <= '0; esc_q <= '0;
			ks_q <= '0; ke_q <= '0; vs_q <= '0; nid_q <= '0; cid_q <= '0; dep_q <= '0;
		end else if (acc) begin
			ph_q <= ph_d; pos_q <= pos_d; ld_q <= ld_d; esc_q <= esc_d;
			ks_q <= ks_d; ke_q <= ke_d; vs_q <= vs_d; nid_q <= nid_d; cid_q <= cid_d;
			dep_q <= dep_d;
		end
	end

	// open-object stack: top and next-below cached, rest in memory
	always_ff @(posedge clk) begin
		if (acc && push) begin
			if (dep_q != '0) mem[SA_W'(dep_q - DW'(1))] <= top_q;
			top_q <= new_ent;
			rd_q  <= top_q;
		end else if (acc && pop) begin
			top_q <= rd_q;
			rd_q  <= mem[SA_W'(dep_q - DW'(3))];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/jkv_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jkv_queue
// Four-entry record queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module jkv_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  jkv_pkg::rec_t wr0,
	input  jkv_pkg::rec_t wr1,
	input  wire logic [1:0] wr_cnt,
	output logic          room,
	output jkv_pkg::rec_t head,
	output logic          head_valid,
	input  wire logic     head_take
);
	import jkv_pkg::*;

	rec_t       q_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       rd;

	assign rd         = head_valid && head_take;
	assign head_valid = (cnt_q != 3'd0);
	assign head       = q_q[rp_q];
	assign room       = (cnt_q <= 3'd2);

	// storage
	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0) q_q[wp_q] <= wr0;
		if (wr_cnt == 2'd2) q_q[wp_q + 2'd1] <= wr1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + wr_cnt;
			rp_q  <= rp_q + {1'b0, rd};
			cnt_q <= cnt_q + {1'b0, wr_cnt} - {2'b0, rd};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/json_key_value_span_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_key_value_span_scanner
// Streams a JSON document and reports one span record per key/value pair.
// ----------------------------------------------------------------------------
// Input channel byte_valid/byte_stall carries byte_in and end_of_doc, one
// document byte per transaction. Output channel rec_valid/rec_stall carries
// one record per transaction; a byte yields zero, one or two records and
// last_of_run marks the final record of a byte.
// Throughput: one byte per cycle while byte_stall is low. The parser decides
// everything for a byte in its accept cycle and writes its records into a
// four-entry queue; a record reaches the output once those ahead are taken.
// byte_stall rises while the queue holds more than two records, so a byte is
// taken only when both of its possible records fit; with rec_stall high the
// parser runs on until the queue fills, then waits.
// Nested objects are held on an open-object stack of STACK_DEPTH entries,
// top entries cached in flops, the rest in a single-port memory.
// Reset puts the parser at the start of a document with an empty queue;
// after the end_of_doc byte the parser returns to the document start by itself.
// ----------------------------------------------------------------------------
module json_key_value_span_scanner #(
	parameter int STACK_DEPTH = 32,
	parameter int MAX_RECORDS = 1024,
	parameter int POS_BITS    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        end_of_doc,
	output logic             rec_valid,
	input  wire logic        rec_stall,
	output logic [1:0]       record_kind,
	output logic [9:0]       record_id,
	output logic [9:0]       parent_id,
	output logic             has_parent,
	output logic [31:0]      key_begin,
	output logic [31:0]      key_end,
	output logic [31:0]      val_begin,
	output logic [31:0]      val_end,
	output logic [1:0]       error_code,
	output logic             last_of_run
);
	import jkv_pkg::*;

	rec_t       rec0, rec1, head;
	logic [1:0] rec_cnt;
	logic       room, acc;

	assign byte_stall = !room;
	assign acc = byte_valid && room;

	// parser
	jkv_front #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_RECORDS (MAX_RECORDS),
		.POS_BITS    (POS_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.byte_in    (byte_in),
		.end_of_doc (end_of_doc),
		.rec0       (rec0),
		.rec1       (rec1),
		.rec_cnt    (rec_cnt)
	);

	// record queue
	jkv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr0        (rec0),
		.wr1        (rec1),
		.wr_cnt     (rec_cnt),
		.room       (room),
		.head       (head),
		.head_valid (rec_valid),
		.head_take  (!rec_stall)
	);

	assign record_kind = head.kind;
	assign record_id   = head.id;
	assign parent_id   = head.parent;
	assign has_parent  = head.has_parent;
	assign key_begin   = head.ks;
	assign key_end     = head.ke;
	assign val_begin   = head.vs;
	assign val_end     = head.ve;
	assign error_code  = head.err;
	assign last_of_run = head.last;

endmodule
`default_nettype wire
